FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, skipped while reset is high.
`define GCD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property at each rising edge, reset cycles included.
`define GCD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: design/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Widths, constants and helpers of the great-circle distance pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gcd_pkg;

   localparam int CORDIC_STEPS_DEF = 32;
   localparam int TABLE_LEN = 48;

   localparam int XY_W = 34;
   localparam int Z_W = 33;
   localparam int PROD_W = 32;
   localparam int ROOT_W = 31;
   localparam int REM_W = 61;
   localparam int TRIAL_W = 62;

   typedef logic signed [XY_W-1:0] xy_type;
   typedef logic signed [Z_W-1:0] z_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic [ROOT_W-1:0] root_type;
   typedef logic [REM_W-1:0] rem_type;

   localparam xy_type CORDIC_GAIN = 34'sd652032874;
   localparam logic [30:0] ONE_Q30 = 31'd1073741824;
   localparam logic [30:0] RAD_PER_UNIT = 31'd2012227627;
   localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;
   localparam logic signed [32:0] HALF_TURN = 33'sd1800000000;
   localparam logic signed [32:0] FULL_TURN = 33'sd3600000000;
   localparam logic [22:0] RADIUS_RESET = 23'd6371000;

   localparam logic [29:0] ATAN_TABLE [TABLE_LEN] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
      30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
      30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
      30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
      30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0,
      30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0,
      30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0
   };

   function automatic z_type atan_at(input int idx);
      logic [5:0] sel;
      sel = 6'(idx);
      if (idx < TABLE_LEN) begin
         return z_type'({{(Z_W-30){1'b0}}, ATAN_TABLE[sel]});
      end
      return '0;
   endfunction

   // Q30 x Q30 product back to Q30, round half up, floor shift.
   function automatic prod_type round_q30(input logic signed [2*PROD_W-1:0] p);
      logic signed [2*PROD_W-1:0] s;
      s = p + 64'sd536870912;
      return prod_type'(s >>> 30);
   endfunction

endpackage

`default_nettype wire

FILE: design/gcd_channels.sv
// ----------------------------------------------------------------------------
// gcd_channels
// Valid/ready channels of the great-circle distance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gcd_req_if;
   logic valid;
   logic ready;
   logic signed [30:0] lat_a;
   logic signed [31:0] lon_a;
   logic signed [30:0] lat_b;
   logic signed [31:0] lon_b;
   modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
   modport sink (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface gcd_rsp_if;
   logic valid;
   logic ready;
   logic [34:0] distance_mm;
   modport source (output valid, distance_mm, input ready);
   modport sink (input valid, distance_mm, output ready);
endinterface

interface gcd_csr_if;
   logic valid;
   logic ready;
   logic [22:0] sphere_radius_m;
   modport source (output valid, sphere_radius_m, input ready);
   modport sink (input valid, sphere_radius_m, output ready);
endinterface

`default_nettype wire

FILE: design/gcd_cordic_cell.sv
// ----------------------------------------------------------------------------
// gcd_cordic_cell
// One registered CORDIC micro-rotation, rotation or vectoring mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcd_cordic_cell #(
   parameter int STEP = 0,
   parameter bit VECTOR = 1'b0
) (
   input  wire logic            clock,
   input  wire logic            enable,
   input  wire gcd_pkg::xy_type src_x,
   input  wire gcd_pkg::xy_type src_y,
   input  wire gcd_pkg::z_type  src_z,
   output gcd_pkg::xy_type      x_ff,
   output gcd_pkg::xy_type      y_ff,
   output gcd_pkg::z_type       z_ff
);

   gcd_pkg::xy_type dx;
   gcd_pkg::xy_type dy;
   gcd_pkg::z_type ang;
   logic turn_back;
   gcd_pkg::xy_type x_in;
   gcd_pkg::xy_type y_in;
   gcd_pkg::z_type z_in;

   always_comb begin
      dx = src_y >>> STEP;
      dy = src_x >>> STEP;
      ang = gcd_pkg::atan_at(STEP);
      // vectoring drives y toward zero, rotation drives z toward zero
      if (VECTOR) begin
         turn_back = !src_y[gcd_pkg::XY_W-1] && (src_y != '0);
      end else begin
         turn_back = src_z[gcd_pkg::Z_W-1];
      end
      if (turn_back) begin
         x_in = src_x + dx;
         y_in = src_y - dy;
         z_in = src_z + ang;
      end else begin
         x_in = src_x - dx;
         y_in = src_y + dy;
         z_in = src_z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/gcd_isqrt_cell.sv
// ----------------------------------------------------------------------------
// gcd_isqrt_cell
// One registered digit of a bit-by-bit integer square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcd_isqrt_cell #(
   parameter int BIT = 0
) (
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire gcd_pkg::rem_type  src_rem,
   input  wire gcd_pkg::root_type src_root,
   output gcd_pkg::rem_type       rem_ff,
   output gcd_pkg::root_type      root_ff
);

   logic [gcd_pkg::TRIAL_W-1:0] trial;
   gcd_pkg::rem_type rem_in;
   gcd_pkg::root_type root_in;

   always_comb begin
      // (r + 2^k)^2 - r^2 with r holding only bits above k
      trial = (gcd_pkg::TRIAL_W'(src_root) << (BIT + 1))
            | (gcd_pkg::TRIAL_W'(1) << (2 * BIT));
      if ({1'b0, src_rem} >= trial) begin
         rem_in = src_rem - trial[gcd_pkg::REM_W-1:0];
         root_in = src_root | (gcd_pkg::ROOT_W'(1) << BIT);
      end else begin
         rem_in = src_rem;
         root_in = src_root;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         root_ff <= root_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/great_circle_distance.sv
// ----------------------------------------------------------------------------
// great_circle_distance
// Haversine distance between two positions, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one position pair per transaction (lat/lon in 1e-7 degree).
//   rsp_if returns the distance in millimetres, one transaction per request,
//   in request order. csr_if writes the sphere radius in metres; it is always
//   ready and must only be written while no request is in flight.
//   The pipeline holds two CORDIC cell rows, a 31-cell square-root row and
//   nine arithmetic stages. A new request is taken every cycle while the
//   output is not stalled; the rate is then one transaction per clock.
//   When the receiver holds rsp_if.ready low with a result waiting, the whole
//   pipeline freezes and req_if.ready drops until the result is taken.
//   Reset empties the pipeline and restores the radius to 6371000 m.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module great_circle_distance #(
   parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   gcd_req_if.sink   req_if,
   gcd_rsp_if.source rsp_if,
   gcd_csr_if.sink   csr_if
);

   localparam int N = CORDIC_STEPS;
   localparam int ROOT_STEPS = gcd_pkg::ROOT_W;
   localparam int LAT = 2 * N + 40;
   localparam int IDX_CORDIC = 4;
   localparam int IDX_H = IDX_CORDIC + N + 2;

   logic [22:0] radius_ff;
   logic vld_ff [LAT];
   logic advance;

   assign advance = !vld_ff[LAT-1] || rsp_if.ready;
   assign req_if.ready = advance;
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= gcd_pkg::RADIUS_RESET;
      end else if (csr_if.valid) begin
         radius_ff <= csr_if.sphere_radius_m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req_if.valid;
         for (int i = 1; i < LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // stage 1: saturate latitudes, take differences
   logic signed [30:0] lat1_in, lat2_in, lat1_ff, lat2_ff;
   logic signed [31:0] dlat_ff;
   logic signed [32:0] dlon_ff;

   always_comb begin
      lat1_in = req_if.lat_a;
      if (req_if.lat_a > gcd_pkg::LAT_LIMIT) lat1_in = gcd_pkg::LAT_LIMIT;
      if (req_if.lat_a < -gcd_pkg::LAT_LIMIT) lat1_in = -gcd_pkg::LAT_LIMIT;
      lat2_in = req_if.lat_b;
      if (req_if.lat_b > gcd_pkg::LAT_LIMIT) lat2_in = gcd_pkg::LAT_LIMIT;
      if (req_if.lat_b < -gcd_pkg::LAT_LIMIT) lat2_in = -gcd_pkg::LAT_LIMIT;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lat1_ff <= lat1_in;
         lat2_ff <= lat2_in;
         dlat_ff <= 32'(lat2_in) - 32'(lat1_in);
         dlon_ff <= 33'(req_if.lon_b) - 33'(req_if.lon_a);
      end
   end

   // stage 2: wrap longitude difference, split sign and magnitude
   logic signed [31:0] dlon_w;
   logic signed [31:0] lane_val [4];
   logic [30:0] mag_ff [4];
   logic neg_s2_ff [4], neg_s3_ff [4];

   always_comb begin
      if (dlon_ff >= gcd_pkg::HALF_TURN) begin
         dlon_w = 32'(dlon_ff - gcd_pkg::FULL_TURN);
      end else if (dlon_ff < -gcd_pkg::HALF_TURN) begin
         dlon_w = 32'(dlon_ff + gcd_pkg::FULL_TURN);
      end else begin
         dlon_w = 32'(dlon_ff);
      end
      lane_val[0] = 32'(lat1_ff);
      lane_val[1] = 32'(lat2_ff);
      lane_val[2] = dlat_ff;
      lane_val[3] = dlon_w;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            neg_s2_ff[i] <= lane_val[i][31];
            mag_ff[i] <= lane_val[i][31] ? 31'(-lane_val[i]) : lane_val[i][30:0];
         end
      end
   end

   // stage 3: scale to radians in Q60
   logic [61:0] rad_ff [4];

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            rad_ff[i] <= 62'(mag_ff[i]) * 62'(gcd_pkg::RAD_PER_UNIT);
            neg_s3_ff[i] <= neg_s2_ff[i];
         end
      end
   end

   // stage 4: round to Q30 (half angles for the differences), reapply sign
   logic [61:0] rad_rnd [4];
   logic [30:0] ang_mag [4];
   gcd_pkg::z_type ang_ff [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (i < 2) begin
            rad_rnd[i] = rad_ff[i] + (62'(1) << 29);
            ang_mag[i] = rad_rnd[i][60:30];
         end else begin
            rad_rnd[i] = rad_ff[i] + (62'(1) << 30);
            ang_mag[i] = rad_rnd[i][61:31];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            ang_ff[i] <= neg_s3_ff[i] ? -gcd_pkg::Z_W'(ang_mag[i])
                                      : gcd_pkg::Z_W'(ang_mag[i]);
         end
      end
   end

   // sine/cosine rows: one lane per angle
   gcd_pkg::xy_type rx [4][N+1];
   gcd_pkg::xy_type ry [4][N+1];
   gcd_pkg::z_type rz [4][N+1];

   for (genvar ln = 0; ln < 4; ln++) begin : g_rot_lane
      assign rx[ln][0] = gcd_pkg::CORDIC_GAIN;
      assign ry[ln][0] = '0;
      assign rz[ln][0] = ang_ff[ln];
      for (genvar st = 0; st < N; st++) begin : g_rot_cell
         gcd_cordic_cell #(.STEP(st), .VECTOR(1'b0)) u_cell (
            .clock  (clock),
            .enable (advance),
            .src_x  (rx[ln][st]),
            .src_y  (ry[ln][st]),
            .src_z  (rz[ln][st]),
            .x_ff   (rx[ln][st+1]),
            .y_ff   (ry[ln][st+1]),
            .z_ff   (rz[ln][st+1])
         );
      end
   end

   // haversine term
   gcd_pkg::prod_type cos1, cos2, sin_dlat, sin_dlon;
   gcd_pkg::prod_type sl2_ff, cc_ff, so2_ff, sl2_d_ff, t_ff;
   logic signed [32:0] h_sum;
   logic [30:0] h_in, h_ff, hc_ff;

   assign cos1 = gcd_pkg::PROD_W'(rx[0][N]);
   assign cos2 = gcd_pkg::PROD_W'(rx[1][N]);
   assign sin_dlat = gcd_pkg::PROD_W'(ry[2][N]);
   assign sin_dlon = gcd_pkg::PROD_W'(ry[3][N]);

   always_ff @(posedge clock) begin
      if (advance) begin
         sl2_ff <= gcd_pkg::round_q30(64'(sin_dlat) * 64'(sin_dlat));
         cc_ff <= gcd_pkg::round_q30(64'(cos1) * 64'(cos2));
         so2_ff <= gcd_pkg::round_q30(64'(sin_dlon) * 64'(sin_dlon));
         sl2_d_ff <= sl2_ff;
         t_ff <= gcd_pkg::round_q30(64'(cc_ff) * 64'(so2_ff));
      end
   end

   always_comb begin
      h_sum = 33'(sl2_d_ff) + 33'(t_ff);
      if (h_sum[32]) begin
         h_in = '0;
      end else if (h_sum > 33'(gcd_pkg::ONE_Q30)) begin
         h_in = gcd_pkg::ONE_Q30;
      end else begin
         h_in = h_sum[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         h_ff <= h_in;
         hc_ff <= gcd_pkg::ONE_Q30 - h_in;
      end
   end

   // square-root rows: sqrt(h) and sqrt(1 - h), one root bit per cell
   gcd_pkg::rem_type srem [2][ROOT_STEPS+1];
   gcd_pkg::root_type sroot [2][ROOT_STEPS+1];

   assign srem[0][0] = {h_ff, 30'b0};
   assign srem[1][0] = {hc_ff, 30'b0};

   for (genvar ln = 0; ln < 2; ln++) begin : g_sqrt_lane
      assign sroot[ln][0] = '0;
      for (genvar st = 0; st < ROOT_STEPS; st++) begin : g_sqrt_cell
         gcd_isqrt_cell #(.BIT(ROOT_STEPS - 1 - st)) u_cell (
            .clock    (clock),
            .enable   (advance),
            .src_rem  (srem[ln][st]),
            .src_root (sroot[ln][st]),
            .rem_ff   (srem[ln][st+1]),
            .root_ff  (sroot[ln][st+1])
         );
      end
   end

   // arcsine row: angle of (sqrt(1-h), sqrt(h))
   gcd_pkg::xy_type vx [N+1];
   gcd_pkg::xy_type vy [N+1];
   gcd_pkg::z_type vz [N+1];

   assign vx[0] = gcd_pkg::XY_W'(sroot[1][ROOT_STEPS]);
   assign vy[0] = gcd_pkg::XY_W'(sroot[0][ROOT_STEPS]);
   assign vz[0] = '0;

   for (genvar st = 0; st < N; st++) begin : g_vec_cell
      gcd_cordic_cell #(.STEP(st), .VECTOR(1'b1)) u_cell (
         .clock  (clock),
         .enable (advance),
         .src_x  (vx[st]),
         .src_y  (vy[st]),
         .src_z  (vz[st]),
         .x_ff   (vx[st+1]),
         .y_ff   (vy[st+1]),
         .z_ff   (vz[st+1])
      );
   end

   // scale by radius, convert to millimetres
   logic [30:0] theta;
   logic [53:0] q_ff;
   logic [60:0] mm_full;
   logic [34:0] dist_ff;

   assign theta = vz[N][gcd_pkg::Z_W-1] ? '0 : vz[N][30:0];
   assign mm_full = 61'(q_ff) * 61'd125 + (61'(1) << 25);

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff <= 54'(radius_ff) * 54'(theta);
         dist_ff <= mm_full[60:26];
      end
   end

   assign rsp_if.valid = vld_ff[LAT-1];
   assign rsp_if.distance_mm = dist_ff;

   `GCD_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_if.valid)
   `GCD_ASSERT(a_ready_only_on_stall, clock, reset, !req_if.ready |-> rsp_if.valid)
   `GCD_ASSERT(a_out_from_pipe, clock, reset, $rose(rsp_if.valid) |-> $past(vld_ff[LAT-2]))
   `GCD_ASSERT(a_h_in_range, clock, reset, vld_ff[IDX_H] |-> (h_ff <= gcd_pkg::ONE_Q30))

endmodule

`default_nettype wire
